// ----- rtl/phh_pkg.sv -----
// Shared types and constants for the packet header parser.
// Used by the parser core, the result buffer, the top level and the checker.
package phh_pkg;

  localparam int FRAME_COUNTER_BITS = 16;
  localparam logic [1:0] MAX_VLAN_TAGS = 2'd2;
  localparam logic [FRAME_COUNTER_BITS-1:0] COUNT_MAX = '1;

  localparam int OUT_DATA_W = 272;

  localparam logic [15:0] ETH_VLAN_Q  = 16'h8100;
  localparam logic [15:0] ETH_VLAN_AD = 16'h88A8;
  localparam logic [15:0] ETH_IPV4    = 16'h0800;
  localparam logic [15:0] ETH_IPV6    = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] DNS_PORT    = 16'd53;

  localparam logic [2:0] OUT_REJECT   = 3'd0;
  localparam logic [2:0] OUT_IP4_TCP  = 3'd1;
  localparam logic [2:0] OUT_IP6_TCP  = 3'd3;
  localparam logic [2:0] OUT_IP6_UDP  = 3'd4;

  localparam logic [1:0] HINT_NONE = 2'd0;
  localparam logic [1:0] HINT_HTTP = 2'd1;
  localparam logic [1:0] HINT_TLS  = 2'd2;
  localparam logic [1:0] HINT_DNS  = 2'd3;

  // Everything known about one frame once its last beat has been seen.
  typedef struct packed {
    logic        reject;
    logic [2:0]  outcome;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [7:0]  tcp_flag_bits;
    logic [1:0]  traffic_hint;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [63:0] src_high;
    logic [63:0] src_low;
    logic [63:0] dst_high;
    logic [63:0] dst_low;
  } frame_sum_t;

endpackage

// ----- rtl/packet_header_parser.sv -----
// Top level of the packet header parser.
// Instantiates phh_parser and phh_out; uses phh_pkg.
//
// Usage:
// The slave channel takes one frame byte per beat, tdata[7:0] the byte and
// tlast set on the final byte. Headers are parsed on the fly: Ethernet with
// up to two VLAN tags, IPv4 or IPv6, then TCP or UDP.
// After the last byte of a frame the master channel gives one reject beat,
// or two beats for an accepted frame: the source address first, then the
// destination address with tlast set.
// Latency: the first result beat is valid in the cycle after the last byte
// is accepted. Throughput: one byte per cycle. Only a last byte can stall,
// since only it loads the single-frame result register: it waits while a
// previous frame still has more than one result beat left, or one beat that
// is not taken in that cycle. Other bytes are accepted in every cycle, so
// s_tready follows s_tlast combinationally.
// Reset clears the frame state and drops any pending results. When the
// receiver holds tready low, results stay put and input stalls at the next
// last byte.
module packet_header_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // frame_byte
  input  logic                              s_tlast,   // frame_end
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // outcome[2:0], src_port[18:3], dst_port[34:19], seq_number[66:35],
  // ack_number[98:67], tcp_flag_bits[106:99], traffic_hint[108:107],
  // payload_offset[124:109], payload_length[140:125], addr_high[204:141],
  // addr_low[268:205], zero fill [271:269]
  output logic [phh_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tlast    // run_last
);

  logic beat, done, free;
  phh_pkg::frame_sum_t sum;

  // Only a last byte needs room in the result register.
  assign s_tready = free || !s_tlast;
  assign beat     = s_tvalid && s_tready;

  phh_parser u_parser (
    .clk(clk), .rst(rst), .beat(beat), .frame_byte(s_tdata), .frame_end(s_tlast),
    .done(done), .sum(sum)
  );

  phh_out u_out (
    .clk(clk), .rst(rst), .load(done), .sum(sum), .free(free),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

endmodule

// ----- rtl/phh_parser.sv -----
// Byte-serial header parser core: walks the frame headers one beat at a time.
// Depends on phh_pkg for constants and the frame summary type.
module phh_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               beat,
  input  logic [7:0]         frame_byte,
  input  logic               frame_end,
  output logic               done,
  output phh_pkg::frame_sum_t sum
);

  typedef enum logic [3:0] {
    PH_ETH, PH_VLAN, PH_IP4, PH_IP4OPT, PH_IP6, PH_TCP, PH_TCPOPT, PH_UDP, PH_PAY
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] pos, pos_next;
  logic [15:0] ether_type, ether_type_next;
  logic [1:0]  vlan_cnt, vlan_cnt_next;
  logic [15:0] tstart, tstart_next;
  logic [7:0]  proto, proto_next;
  logic [15:0] pstart, pstart_next;
  logic [63:0] src_hi, src_hi_next, src_lo, src_lo_next;
  logic [63:0] dst_hi, dst_hi_next, dst_lo, dst_lo_next;
  logic [15:0] sport, sport_next, dport, dport_next;
  logic [31:0] seq, seq_next, ack, ack_next;
  logic [7:0]  flags, flags_next;
  logic [7:0]  head [6];
  logic [7:0]  head_next [6];
  logic        rejected, rejected_next;

  logic [15:0] l3, r_l3, r_tr, r_pay;
  logic [16:0] pos_inc;
  logic [15:0] et_v;
  logic [1:0]  vc_v;
  logic        route;
  logic [15:0] plen;
  logic [1:0]  hint;

  assign l3      = 16'd14 + {12'd0, vlan_cnt, 2'b00};
  assign r_l3    = pos - l3;
  assign r_tr    = pos - tstart;
  assign r_pay   = pos - pstart;
  assign pos_inc = {1'b0, pos} + 17'd1;

  // Next frame state from the current beat.
  always_comb begin
    phase_next = phase;       pos_next = pos;         ether_type_next = ether_type;
    vlan_cnt_next = vlan_cnt; tstart_next = tstart;   proto_next = proto;
    pstart_next = pstart;     src_hi_next = src_hi;   src_lo_next = src_lo;
    dst_hi_next = dst_hi;     dst_lo_next = dst_lo;   sport_next = sport;
    dport_next = dport;       seq_next = seq;         ack_next = ack;
    flags_next = flags;       rejected_next = rejected;
    for (int i = 0; i < 6; i++) head_next[i] = head[i];
    et_v  = ether_type;
    vc_v  = vlan_cnt;
    route = 1'b0;
    if (beat) begin
      if (pos == phh_pkg::COUNT_MAX) begin
        rejected_next = 1'b1;
      end else begin
        pos_next = pos_inc[15:0];
        if (!rejected) begin
          unique case (phase)
            PH_ETH: begin
              if (pos == 16'd12) ether_type_next = {frame_byte, 8'd0};
              if (pos == 16'd13) begin
                et_v  = {ether_type[15:8], frame_byte};
                ether_type_next = et_v;
                route = 1'b1;
              end
            end
            PH_VLAN: begin
              if (r_l3 == 16'd2) ether_type_next = {frame_byte, 8'd0};
              if (r_l3 == 16'd3) begin
                et_v  = {ether_type[15:8], frame_byte};
                vc_v  = vlan_cnt + 2'd1;
                ether_type_next = et_v;
                vlan_cnt_next = vc_v;
                route = 1'b1;
              end
            end
            PH_IP4: begin
              if (r_l3 == 16'd0) begin
                if (frame_byte[3:0] < 4'd5) rejected_next = 1'b1;
                else tstart_next = l3 + {10'd0, frame_byte[3:0], 2'b00};
              end else if (r_l3 == 16'd9) begin
                if (frame_byte != phh_pkg::PROTO_TCP && frame_byte != phh_pkg::PROTO_UDP)
                  rejected_next = 1'b1;
                else proto_next = frame_byte;
              end else if (r_l3 >= 16'd12 && r_l3 <= 16'd15) begin
                src_lo_next = {src_lo[55:0], frame_byte};
              end else if (r_l3 >= 16'd16 && r_l3 <= 16'd19) begin
                dst_lo_next = {dst_lo[55:0], frame_byte};
              end
              if (r_l3 == 16'd19) begin
                if (pos_inc == {1'b0, tstart})
                  phase_next = (proto == phh_pkg::PROTO_TCP) ? PH_TCP : PH_UDP;
                else phase_next = PH_IP4OPT;
              end
            end
            PH_IP4OPT: begin
              if (pos_inc == {1'b0, tstart})
                phase_next = (proto == phh_pkg::PROTO_TCP) ? PH_TCP : PH_UDP;
            end
            PH_IP6: begin
              if (r_l3 == 16'd6) begin
                if (frame_byte != phh_pkg::PROTO_TCP && frame_byte != phh_pkg::PROTO_UDP)
                  rejected_next = 1'b1;
                else proto_next = frame_byte;
              end else if (r_l3 >= 16'd8 && r_l3 <= 16'd15) begin
                src_hi_next = {src_hi[55:0], frame_byte};
              end else if (r_l3 >= 16'd16 && r_l3 <= 16'd23) begin
                src_lo_next = {src_lo[55:0], frame_byte};
              end else if (r_l3 >= 16'd24 && r_l3 <= 16'd31) begin
                dst_hi_next = {dst_hi[55:0], frame_byte};
              end else if (r_l3 >= 16'd32 && r_l3 <= 16'd39) begin
                dst_lo_next = {dst_lo[55:0], frame_byte};
              end
              if (r_l3 == 16'd39) begin
                tstart_next = pos_inc[15:0];
                phase_next = (proto == phh_pkg::PROTO_TCP) ? PH_TCP : PH_UDP;
              end
            end
            PH_TCP: begin
              if (r_tr <= 16'd3) begin
                if (r_tr[1]) dport_next = {dport[7:0], frame_byte};
                else sport_next = {sport[7:0], frame_byte};
              end else if (r_tr <= 16'd11) begin
                if (r_tr[3]) ack_next = {ack[23:0], frame_byte};
                else seq_next = {seq[23:0], frame_byte};
              end else if (r_tr == 16'd12) begin
                if (frame_byte[7:4] < 4'd5) rejected_next = 1'b1;
                else pstart_next = tstart + {10'd0, frame_byte[7:4], 2'b00};
              end else if (r_tr == 16'd13) begin
                flags_next = frame_byte;
              end
              if (r_tr == 16'd19)
                phase_next = (pos_inc == {1'b0, pstart}) ? PH_PAY : PH_TCPOPT;
            end
            PH_TCPOPT: begin
              if (pos_inc == {1'b0, pstart}) phase_next = PH_PAY;
            end
            PH_UDP: begin
              if (r_tr <= 16'd3) begin
                if (r_tr[1]) dport_next = {dport[7:0], frame_byte};
                else sport_next = {sport[7:0], frame_byte};
              end
              if (r_tr == 16'd7) begin
                pstart_next = pos_inc[15:0];
                phase_next = PH_PAY;
              end
            end
            PH_PAY: begin
              if (r_pay < 16'd6) head_next[r_pay[2:0]] = frame_byte;
            end
            default: rejected_next = 1'b1;
          endcase
          // Dispatch on a completed EtherType.
          if (route) begin
            if ((et_v == phh_pkg::ETH_VLAN_Q || et_v == phh_pkg::ETH_VLAN_AD) &&
                vc_v < phh_pkg::MAX_VLAN_TAGS)
              phase_next = PH_VLAN;
            else if (et_v == phh_pkg::ETH_IPV4) phase_next = PH_IP4;
            else if (et_v == phh_pkg::ETH_IPV6) phase_next = PH_IP6;
            else rejected_next = 1'b1;
          end
        end
      end
    end
  end

  // Frame summary taken from the state as it stands after the final beat.
  assign plen = pos_next - pstart_next;

  always_comb begin
    if (proto_next == phh_pkg::PROTO_UDP &&
        (sport_next == phh_pkg::DNS_PORT || dport_next == phh_pkg::DNS_PORT))
      hint = phh_pkg::HINT_DNS;
    else if (plen < 16'd8)
      hint = phh_pkg::HINT_NONE;
    else if (head_next[0] == "G" && head_next[1] == "E" && head_next[2] == "T" &&
             head_next[3] == " ")
      hint = phh_pkg::HINT_HTTP;
    else if (head_next[0] == "P" && head_next[1] == "O" && head_next[2] == "S" &&
             head_next[3] == "T")
      hint = phh_pkg::HINT_HTTP;
    else if (head_next[0] == 8'h16 && head_next[5] == 8'h01)
      hint = phh_pkg::HINT_TLS;
    else
      hint = phh_pkg::HINT_NONE;
  end

  always_comb begin
    sum.reject         = rejected_next || (phase_next != PH_PAY);
    sum.outcome        = ((ether_type_next == phh_pkg::ETH_IPV6) ? phh_pkg::OUT_IP6_TCP
                                                                 : phh_pkg::OUT_IP4_TCP) +
                         {2'd0, proto_next == phh_pkg::PROTO_UDP};
    sum.src_port       = sport_next;
    sum.dst_port       = dport_next;
    sum.seq_number     = seq_next;
    sum.ack_number     = ack_next;
    sum.tcp_flag_bits  = flags_next;
    sum.traffic_hint   = hint;
    sum.payload_offset = pstart_next;
    sum.payload_length = plen;
    sum.src_high       = src_hi_next;
    sum.src_low        = src_lo_next;
    sum.dst_high       = dst_hi_next;
    sum.dst_low        = dst_lo_next;
  end

  assign done = beat && frame_end;

  // State registers; the frame state returns to reset after every last beat.
  always_ff @(posedge clk) begin
    if (rst || done) begin
      phase <= PH_ETH; pos <= '0; ether_type <= '0; vlan_cnt <= '0; tstart <= '0;
      proto <= '0; pstart <= '0; src_hi <= '0; src_lo <= '0; dst_hi <= '0;
      dst_lo <= '0; sport <= '0; dport <= '0; seq <= '0; ack <= '0; flags <= '0;
      rejected <= 1'b0;
      for (int i = 0; i < 6; i++) head[i] <= '0;
    end else begin
      phase <= phase_next; pos <= pos_next; ether_type <= ether_type_next;
      vlan_cnt <= vlan_cnt_next; tstart <= tstart_next; proto <= proto_next;
      pstart <= pstart_next; src_hi <= src_hi_next; src_lo <= src_lo_next;
      dst_hi <= dst_hi_next; dst_lo <= dst_lo_next; sport <= sport_next;
      dport <= dport_next; seq <= seq_next; ack <= ack_next; flags <= flags_next;
      rejected <= rejected_next;
      for (int i = 0; i < 6; i++) head[i] <= head_next[i];
    end
  end

endmodule

// ----- rtl/phh_out.sv -----
// Result buffer: holds one frame summary and plays it out as one or two beats.
// Depends on phh_pkg for the summary type and output packing width.
module phh_out (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  phh_pkg::frame_sum_t              sum,
  output logic                             free,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [phh_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                             m_tlast
);

  phh_pkg::frame_sum_t held;
  logic [1:0] pend;
  logic [63:0] a_hi, a_lo;

  assign m_tvalid = (pend != 2'd0);
  assign free     = (pend == 2'd0) || (pend == 2'd1 && m_tready);
  assign m_tlast  = (pend != 2'd2);

  // The first beat carries the source address, the second the destination.
  assign a_hi = (pend == 2'd2) ? held.src_high : held.dst_high;
  assign a_lo = (pend == 2'd2) ? held.src_low  : held.dst_low;

  always_comb begin
    if (held.reject) begin
      m_tdata = '0;
    end else begin
      m_tdata = {3'd0, a_lo, a_hi, held.payload_length, held.payload_offset,
                 held.traffic_hint, held.tcp_flag_bits, held.ack_number, held.seq_number,
                 held.dst_port, held.src_port, held.outcome};
    end
  end

  // Beat counter for the held summary.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
    end else if (load) begin
      pend <= sum.reject ? 2'd1 : 2'd2;
    end else if (m_tvalid && m_tready) begin
      pend <= pend - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= sum;
  end

endmodule

// ----- rtl/phh_checker.sv -----
// Port-level checks for the packet header parser, bound to the top level.
// Depends on the top-level ports and the outcome codes in phh_pkg.
module phh_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [271:0] m_tdata,
  input logic         m_tlast
);

  // A stalled result beat stays valid.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result beat dropped");

  // A reject is always a single beat.
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == phh_pkg::OUT_REJECT |-> m_tlast)
    else $error("reject not last");

  // The destination beat follows the source beat at once.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
    else $error("second result beat missing");

  // Outcome codes stay in range.
  a_outcome: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= phh_pkg::OUT_IP6_UDP) else $error("bad outcome code");

endmodule

bind packet_header_parser phh_checker u_phh_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tlast(m_tlast)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for packet_header_parser.
// Streams frames byte by byte, predicts the parsed header results and checks them.
`timescale 1ns / 100ps

module tb_top;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_BYTES = 310;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [7:0]  tcp_flag_bits;
    logic [1:0]  traffic_hint;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        run_last;
  } hdr_result_t;

  typedef enum logic [3:0] {
    ST_ETH, ST_VLAN, ST_IP4, ST_IP4OPT, ST_IP6, ST_TCP, ST_TCPOPT, ST_UDP, ST_PAY
  } parse_st_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [phh_pkg::OUT_DATA_W-1:0] m_tdata;
  logic m_tlast;

  packet_header_parser dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Pending bytes: {last, byte}.
  logic [8:0] byte_queue[$];
  hdr_result_t expected_results[$];
  int send_idle_pct = 22;
  int recv_idle_pct = 72;
  int mismatch_count = 0;
  int queued_bytes = 0;
  bit stim_done = 1'b0;
  longint cycle_count = 0;

  // Predictor state, one frame at a time.
  parse_st_t pst;
  int unsigned bpos, ether_type, vlan_cnt, xport_start, proto, pay_start, flags_r;
  logic [63:0] src_a[2], dst_a[2];
  logic [15:0] ports[2];
  logic [31:0] seqack[2];
  logic [7:0] phead[6];
  bit rej;

  function automatic void clear_parser();
    pst = ST_ETH; bpos = 0; ether_type = 0; vlan_cnt = 0; xport_start = 0;
    proto = 0; pay_start = 0; flags_r = 0; rej = 0;
    src_a = '{64'd0, 64'd0}; dst_a = '{64'd0, 64'd0};
    ports = '{16'd0, 16'd0}; seqack = '{32'd0, 32'd0};
    for (int i = 0; i < 6; i++) phead[i] = 8'd0;
  endfunction

  function automatic int unsigned l3_base();
    return 14 + 4 * vlan_cnt;
  endfunction

  function automatic void route_ether_type();
    if ((ether_type == phh_pkg::ETH_VLAN_Q || ether_type == phh_pkg::ETH_VLAN_AD) &&
        vlan_cnt < phh_pkg::MAX_VLAN_TAGS)
      pst = ST_VLAN;
    else if (ether_type == phh_pkg::ETH_IPV4) pst = ST_IP4;
    else if (ether_type == phh_pkg::ETH_IPV6) pst = ST_IP6;
    else rej = 1;
  endfunction

  function automatic void parse_byte(int unsigned b, int unsigned pos);
    int unsigned r;
    if (rej) return;
    case (pst)
      ST_ETH: begin
        if (pos == 12) ether_type = b << 8;
        if (pos == 13) begin
          ether_type |= b;
          route_ether_type();
        end
      end
      ST_VLAN: begin
        r = pos - l3_base();
        if (r == 2) ether_type = b << 8;
        if (r == 3) begin
          ether_type |= b;
          vlan_cnt = (vlan_cnt + 1) & 3;
          route_ether_type();
        end
      end
      ST_IP4: begin
        r = pos - l3_base();
        if (r == 0) begin
          if ((b & 15) < 5) begin
            rej = 1;
            return;
          end
          xport_start = l3_base() + (b & 15) * 4;
        end else if (r == 9) begin
          if (b != phh_pkg::PROTO_TCP && b != phh_pkg::PROTO_UDP) begin
            rej = 1;
            return;
          end
          proto = b;
        end else if (r >= 12 && r <= 15) src_a[1] = (src_a[1] << 8) | b;
        else if (r >= 16 && r <= 19) dst_a[1] = (dst_a[1] << 8) | b;
        if (r == 19) begin
          if (pos + 1 == xport_start)
            pst = (proto == phh_pkg::PROTO_TCP) ? ST_TCP : ST_UDP;
          else pst = ST_IP4OPT;
        end
      end
      ST_IP4OPT: begin
        if (pos + 1 == xport_start) pst = (proto == phh_pkg::PROTO_TCP) ? ST_TCP : ST_UDP;
      end
      ST_IP6: begin
        r = pos - l3_base();
        if (r == 6) begin
          if (b != phh_pkg::PROTO_TCP && b != phh_pkg::PROTO_UDP) begin
            rej = 1;
            return;
          end
          proto = b;
        end else if (r >= 8 && r <= 23) src_a[(r-8)>>3] = (src_a[(r-8)>>3] << 8) | b;
        else if (r >= 24 && r <= 39) dst_a[(r-24)>>3] = (dst_a[(r-24)>>3] << 8) | b;
        if (r == 39) begin
          xport_start = pos + 1;
          pst = (proto == phh_pkg::PROTO_TCP) ? ST_TCP : ST_UDP;
        end
      end
      ST_TCP: begin
        r = pos - xport_start;
        if (r <= 3) ports[r>>1] = 16'((ports[r>>1] << 8) | b);
        else if (r <= 11) seqack[(r-4)>>2] = (seqack[(r-4)>>2] << 8) | b;
        else if (r == 12) begin
          if ((b >> 4) < 5) begin
            rej = 1;
            return;
          end
          pay_start = xport_start + (b >> 4) * 4;
        end else if (r == 13) flags_r = b;
        if (r == 19) pst = (pos + 1 == pay_start) ? ST_PAY : ST_TCPOPT;
      end
      ST_TCPOPT: begin
        if (pos + 1 == pay_start) pst = ST_PAY;
      end
      ST_UDP: begin
        r = pos - xport_start;
        if (r <= 3) ports[r>>1] = 16'((ports[r>>1] << 8) | b);
        if (r == 7) begin
          pay_start = pos + 1;
          pst = ST_PAY;
        end
      end
      ST_PAY: begin
        r = pos - pay_start;
        if (r < 6) phead[r] = 8'(b);
      end
      default: rej = 1;
    endcase
  endfunction

  function automatic logic [1:0] content_hint(int unsigned plen);
    if (proto == phh_pkg::PROTO_UDP &&
        (ports[0] == phh_pkg::DNS_PORT || ports[1] == phh_pkg::DNS_PORT))
      return phh_pkg::HINT_DNS;
    if (plen < 8) return phh_pkg::HINT_NONE;
    if (phead[0] == "G" && phead[1] == "E" && phead[2] == "T" && phead[3] == " ")
      return phh_pkg::HINT_HTTP;
    if (phead[0] == "P" && phead[1] == "O" && phead[2] == "S" && phead[3] == "T")
      return phh_pkg::HINT_HTTP;
    if (phead[0] == 8'h16 && phead[5] == 8'h01) return phh_pkg::HINT_TLS;
    return phh_pkg::HINT_NONE;
  endfunction

  // Advance the predictor by one accepted byte and queue any results.
  function automatic void predict_byte(logic [7:0] b, logic last);
    hdr_result_t res;
    int unsigned plen;
    if (bpos >= phh_pkg::COUNT_MAX) rej = 1;
    else begin
      parse_byte(b, bpos);
      bpos++;
    end
    if (!last) return;
    res = '0;
    if (rej || pst != ST_PAY) begin
      res.run_last = 1'b1;
      expected_results.push_back(res);
    end else begin
      plen = bpos - pay_start;
      res.outcome = ((ether_type == phh_pkg::ETH_IPV6) ? phh_pkg::OUT_IP6_TCP
                                                      : phh_pkg::OUT_IP4_TCP)
                    + ((proto == phh_pkg::PROTO_UDP) ? 3'd1 : 3'd0);
      res.src_port = ports[0];
      res.dst_port = ports[1];
      res.seq_number = seqack[0];
      res.ack_number = seqack[1];
      res.tcp_flag_bits = 8'(flags_r);
      res.traffic_hint = content_hint(plen);
      res.payload_offset = 16'(pay_start);
      res.payload_length = 16'(plen);
      res.addr_high = src_a[0];
      res.addr_low = src_a[1];
      res.run_last = 1'b0;
      expected_results.push_back(res);
      res.addr_high = dst_a[0];
      res.addr_low = dst_a[1];
      res.run_last = 1'b1;
      expected_results.push_back(res);
    end
    clear_parser();
  endfunction

  // Driver: present the queued bytes, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) predict_byte(s_tdata, s_tlast);
      if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        {s_tlast, s_tdata} <= byte_queue.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    hdr_result_t want, got;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        got.outcome = m_tdata[2:0];
        got.src_port = m_tdata[18:3];
        got.dst_port = m_tdata[34:19];
        got.seq_number = m_tdata[66:35];
        got.ack_number = m_tdata[98:67];
        got.tcp_flag_bits = m_tdata[106:99];
        got.traffic_hint = m_tdata[108:107];
        got.payload_offset = m_tdata[124:109];
        got.payload_length = m_tdata[140:125];
        got.addr_high = m_tdata[204:141];
        got.addr_low = m_tdata[268:205];
        got.run_last = m_tlast;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: expected %h actual %h", want, got);
          end
        end
      end
    end
  end

  // Frame builders.
  typedef logic [7:0] byte_list_t[$];

  function automatic void queue_frame(byte_list_t f);
    for (int i = 0; i < f.size(); i++)
      byte_queue.push_back({(i == f.size() - 1), f[i]});
    queued_bytes += f.size();
  endfunction

  function automatic void push_rand(ref byte_list_t f, input int n);
    for (int i = 0; i < n; i++) f.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void push16(ref byte_list_t f, input logic [15:0] v);
    f.push_back(v[15:8]);
    f.push_back(v[7:0]);
  endfunction

  // Random payload with a chosen content signature.
  function automatic void push_payload(ref byte_list_t f, input int n, input int kind);
    byte_list_t p;
    push_rand(p, n);
    if (n >= 6) begin
      case (kind)
        1: begin p[0] = "G"; p[1] = "E"; p[2] = "T"; p[3] = " "; end
        2: begin p[0] = "P"; p[1] = "O"; p[2] = "S"; p[3] = "T"; end
        3: begin p[0] = 8'h16; p[5] = 8'h01; end
        default: ;
      endcase
    end
    foreach (p[i]) f.push_back(p[i]);
  endfunction

  // Build a well-formed frame with the given header shape and payload.
  function automatic byte_list_t make_frame(bit v6, bit tcp, int tags, int ihl, int doff,
                                            int plen, int kind, logic [15:0] sport,
                                            logic [15:0] dport);
    byte_list_t f;
    push_rand(f, 12);
    for (int t = 0; t < tags; t++) begin
      push16(f, $urandom_range(1) ? phh_pkg::ETH_VLAN_Q : phh_pkg::ETH_VLAN_AD);
      push_rand(f, 2);
    end
    push16(f, v6 ? phh_pkg::ETH_IPV6 : phh_pkg::ETH_IPV4);
    if (v6) begin
      push_rand(f, 6);
      f.push_back(tcp ? phh_pkg::PROTO_TCP : phh_pkg::PROTO_UDP);
      push_rand(f, 33);
    end else begin
      f.push_back({4'($urandom_range(15)), 4'(ihl)});
      push_rand(f, 8);
      f.push_back(tcp ? phh_pkg::PROTO_TCP : phh_pkg::PROTO_UDP);
      push_rand(f, 10);
      push_rand(f, (ihl - 5) * 4);
    end
    push16(f, sport);
    push16(f, dport);
    if (tcp) begin
      push_rand(f, 8);
      f.push_back({4'(doff), 4'($urandom_range(15))});
      push_rand(f, 7);
      push_rand(f, (doff - 5) * 4);
    end else begin
      push_rand(f, 4);
    end
    push_payload(f, plen, kind);
    return f;
  endfunction

  function automatic logic [15:0] rand_port();
    return ($urandom_range(7) == 0) ? phh_pkg::DNS_PORT : 16'($urandom);
  endfunction

  initial begin
    byte_list_t f;
    clear_parser();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Three idling phases, each with directed frames and then random fill.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          // Each frame type with hints, options and tags.
          queue_frame(make_frame(0, 1, 0, 5, 5, 10, 1, 16'h0000, 16'hFFFF));
          queue_frame(make_frame(0, 0, 1, 7, 5, 12, 0, 16'd53, 16'h1234));
          queue_frame(make_frame(1, 1, 2, 5, 6, 9, 3, 16'hFFFF, 16'h0000));
          queue_frame(make_frame(1, 0, 0, 5, 5, 8, 2, 16'h1111, 16'd53));
        end
        1: begin
          queue_frame(make_frame(0, 1, 0, 6, 8, 0, 0, 16'h8000, 16'h0001));
          queue_frame(make_frame(0, 1, 0, 5, 5, 7, 1, 16'h0050, 16'h0050));
          queue_frame(make_frame(1, 0, 1, 5, 5, 8, 2, 16'h2222, 16'h3333));
          // Too many tags.
          queue_frame(make_frame(0, 1, 3, 5, 5, 0, 0, 16'h1, 16'h2));
          // Short frame cut inside the IPv6 header.
          f = make_frame(1, 1, 0, 5, 5, 0, 0, 16'h1, 16'h2);
          f = f[0:30];
          queue_frame(f);
        end
        default: begin
          // IHL below five, data offset below five, bad protocol, bad EtherType.
          f = make_frame(0, 0, 0, 5, 5, 0, 0, 16'h1, 16'h2);
          f[14] = 8'h44;
          queue_frame(f);
          f = make_frame(0, 1, 0, 5, 5, 0, 0, 16'h1, 16'h2);
          f[46] = 8'h40;
          queue_frame(f);
          f = make_frame(0, 0, 0, 5, 5, 0, 0, 16'h1, 16'h2);
          f[23] = 8'h01;
          queue_frame(f);
          f = make_frame(0, 0, 0, 5, 5, 0, 0, 16'h1, 16'h2);
          f[12] = 8'h12;
          queue_frame(f);
          // One-byte frame.
          f = {8'hFF};
          queue_frame(f);
        end
      endcase

      // Random frames, mostly well formed.
      while (queued_bytes < (phase + 1) * PHASE_BYTES) begin
        case ($urandom_range(9))
          0: begin
            f = {};
            push_rand(f, $urandom_range(1, 60));
          end
          1: begin
            f = make_frame($urandom_range(1), $urandom_range(1), $urandom_range(3),
                           $urandom_range(5, 15), $urandom_range(5, 15),
                           $urandom_range(0, 12), $urandom_range(3), rand_port(), rand_port());
            f = f[0:$urandom_range(f.size() - 1)];
            f[$urandom_range(f.size() - 1)] = 8'($urandom);
          end
          default: f = make_frame($urandom_range(1), $urandom_range(1), $urandom_range(2),
                                  $urandom_range(5, 15), $urandom_range(5, 15),
                                  $urandom_range(0, 14), $urandom_range(3),
                                  rand_port(), rand_port());
        endcase
        queue_frame(f);
      end
      while (byte_queue.size() > 0 || s_tvalid) @(posedge clk);
      send_idle_pct = (phase == 0) ? 72 : 0;
      recv_idle_pct = (phase == 0) ? 22 : 0;
    end
    stim_done = 1'b1;
  end

  // End of run and timeout.
  initial begin
    @(posedge stim_done);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

// ----- files.f -----
rtl/phh_pkg.sv
rtl/phh_parser.sv
rtl/phh_out.sv
rtl/packet_header_parser.sv
rtl/phh_checker.sv
tb/tb_top.sv
